FILE: hdl/cistp_pkg.sv
// ----------------------------------------------------------------------------
// cistp_pkg
// shared types, constants and helpers for the chunked image stream decoder
// ----------------------------------------------------------------------------
package cistp_pkg;

  localparam int COORD_BITS_DEFAULT = 16;

  localparam logic [15:0] DEFAULT_CHUNK_LEN = 16'd8192;
  localparam logic [7:0]  ASCII_LF          = 8'd10;
  localparam logic [7:0]  ASCII_CR          = 8'd13;
  localparam logic [7:0]  ASCII_SLASH       = 8'd47;
  localparam logic [7:0]  ASCII_ZERO        = 8'd48;
  localparam logic [7:0]  ASCII_NINE        = 8'd57;
  localparam logic [7:0]  ASCII_UPPER_A     = 8'd65;
  localparam logic [7:0]  ASCII_UPPER_F     = 8'd70;
  localparam logic [7:0]  ASCII_LOWER_A     = 8'd97;
  localparam logic [7:0]  ASCII_LOWER_F     = 8'd102;
  localparam logic [7:0]  HEX_ALPHA_BASE    = 8'd10;
  localparam logic [3:0]  HDR_MAX_BYTES     = 4'd10;

  // register indexes on the config port, byte address is index times four
  localparam logic REG_X_ORIGIN = 1'b0;
  localparam logic REG_Y_ORIGIN = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SIZE,
    PH_DATA,
    PH_DONE
  } phase_t;

  // one body byte handed from the chunk parser to the pixel stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } data_evt_t;

  // image geometry as read from the first chunk
  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
  } geom_t;

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
        v = b - ASCII_ZERO;
      end else if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_F) begin
        v = b - ASCII_UPPER_A + HEX_ALPHA_BASE;
      end else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_F) begin
        v = b - ASCII_LOWER_A + HEX_ALPHA_BASE;
      end
      return v[3:0];
    end
  endfunction

endpackage

FILE: hdl/cistp_chunk_parser.sv
// ----------------------------------------------------------------------------
// cistp_chunk_parser
// strips chunk headers, reads the image size bytes, passes body bytes on
// ----------------------------------------------------------------------------
module cistp_chunk_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            stream_byte,
  input  logic                  new_transfer,
  output cistp_pkg::data_evt_t  data_evt,
  output cistp_pkg::geom_t      geom
);
  import cistp_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] size_acc, size_acc_next;
  logic [7:0]  prev_byte, prev_byte_next;
  logic [7:0]  prev_prev_byte, prev_prev_byte_next;
  logic [3:0]  hdr_cnt, hdr_cnt_next;
  logic [15:0] chunk_len, chunk_len_next;
  logic [15:0] chunk_cnt, chunk_cnt_next;
  logic        first_pending, first_pending_next;
  logic [15:0] img_w, img_w_next;
  logic [15:0] img_h, img_h_next;

  // state as seen after an optional transfer restart
  phase_t      ph_e;
  logic [15:0] acc_e, len_e, cnt_e, w_e, h_e;
  logic [7:0]  prev_e, pprev_e;
  logic [3:0]  hcnt_e;
  logic        first_e;

  // state after the end-of-chunk check
  logic        chunk_end;
  phase_t      ph_c;
  logic [15:0] acc_c;
  logic [3:0]  hcnt_c;

  // header byte decode
  logic [3:0]  hcnt_inc;
  logic [15:0] acc_new;
  logic        lf_close, overlong, size_last;
  logic [15:0] cnt_inc;

  assign ph_e    = new_transfer ? PH_HEADER : phase;
  assign acc_e   = new_transfer ? 16'd0 : size_acc;
  assign prev_e  = new_transfer ? 8'd0 : prev_byte;
  assign pprev_e = new_transfer ? 8'd0 : prev_prev_byte;
  assign hcnt_e  = new_transfer ? 4'd0 : hdr_cnt;
  assign len_e   = new_transfer ? DEFAULT_CHUNK_LEN : chunk_len;
  assign cnt_e   = new_transfer ? 16'd0 : chunk_cnt;
  assign first_e = new_transfer ? 1'b1 : first_pending;
  assign w_e     = new_transfer ? 16'd0 : img_w;
  assign h_e     = new_transfer ? 16'd0 : img_h;

  assign chunk_end = (ph_e == PH_DATA) && (cnt_e >= len_e);
  assign ph_c      = chunk_end ? PH_HEADER : ph_e;
  assign acc_c     = chunk_end ? 16'd0 : acc_e;
  assign hcnt_c    = chunk_end ? 4'd0 : hcnt_e;

  assign hcnt_inc  = hcnt_c + 4'd1;
  assign acc_new   = (stream_byte > ASCII_SLASH)
                   ? {acc_c[11:0], 4'd0} + {12'd0, hex_value(stream_byte)}
                   : acc_c;
  assign lf_close  = (stream_byte == ASCII_LF) && (prev_e == ASCII_CR)
                   && (pprev_e > ASCII_SLASH);
  assign overlong  = hcnt_inc > HDR_MAX_BYTES;
  assign cnt_inc   = cnt_e + 16'd1;
  assign size_last = cnt_inc >= 16'd4;

  assign geom.width  = w_e;
  assign geom.height = h_e;

  // next phase
  always_comb begin
    phase_next = ph_c;
    unique case (ph_c)
      PH_HEADER: begin
        if (overlong || (lf_close && acc_new != 16'd0)) begin
          phase_next = first_e ? PH_SIZE : PH_DATA;
        end else if (lf_close) begin
          phase_next = PH_DONE;
        end
      end
      PH_SIZE: begin
        if (size_last) begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: phase_next = PH_DATA;
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_HEADER;
    endcase
  end

  // datapath updates and body byte output
  always_comb begin
    size_acc_next       = acc_c;
    prev_byte_next      = prev_e;
    prev_prev_byte_next = pprev_e;
    hdr_cnt_next        = hcnt_c;
    chunk_len_next      = len_e;
    chunk_cnt_next      = cnt_e;
    first_pending_next  = first_e;
    img_w_next          = w_e;
    img_h_next          = h_e;
    data_evt.valid      = 1'b0;
    data_evt.data       = stream_byte;
    unique case (ph_c)
      PH_HEADER: begin
        hdr_cnt_next        = hcnt_inc;
        size_acc_next       = acc_new;
        prev_prev_byte_next = prev_e;
        prev_byte_next      = stream_byte;
        if (overlong || (lf_close && acc_new != 16'd0)) begin
          chunk_len_next     = overlong ? DEFAULT_CHUNK_LEN : acc_new;
          chunk_cnt_next     = 16'd0;
          first_pending_next = 1'b0;
        end
      end
      PH_SIZE: begin
        chunk_cnt_next = cnt_inc;
        case (cnt_e[1:0])
          2'd0:    img_w_next = {stream_byte, 8'd0};
          2'd1:    img_w_next = w_e | {8'd0, stream_byte};
          2'd2:    img_h_next = {stream_byte, 8'd0};
          default: img_h_next = h_e | {8'd0, stream_byte};
        endcase
      end
      PH_DATA: begin
        chunk_cnt_next = cnt_inc;
        data_evt.valid = 1'b1;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      size_acc       <= 16'd0;
      prev_byte      <= 8'd0;
      prev_prev_byte <= 8'd0;
      hdr_cnt        <= 4'd0;
      chunk_len      <= DEFAULT_CHUNK_LEN;
      chunk_cnt      <= 16'd0;
      first_pending  <= 1'b1;
      img_w          <= 16'd0;
      img_h          <= 16'd0;
    end else if (accept) begin
      phase          <= phase_next;
      size_acc       <= size_acc_next;
      prev_byte      <= prev_byte_next;
      prev_prev_byte <= prev_prev_byte_next;
      hdr_cnt        <= hdr_cnt_next;
      chunk_len      <= chunk_len_next;
      chunk_cnt      <= chunk_cnt_next;
      first_pending  <= first_pending_next;
      img_w          <= img_w_next;
      img_h          <= img_h_next;
    end
  end

endmodule

FILE: hdl/chunked_image_stream_to_pixels.sv
// ----------------------------------------------------------------------------
// chunked_image_stream_to_pixels
// decodes a chunked transfer body carrying an RGB565 image into placed pixels
// ----------------------------------------------------------------------------
// One body byte enters per item on the slave stream and every accepted byte
// is fully processed in the cycle it is taken, so the block sustains one byte
// per clock while no held pixel blocks the result slot; a pixel's second byte
// has its result captured in the result register, which lets a new byte in
// while a held pixel is being taken; input stalls only while it is not taken.
// Chunk headers (hex size, CR LF) are stripped, the first chunk's four leading
// bytes give the image width and height, and every following byte pair gives
// one pixel placed at the configured origin plus a row/column walker; pixels
// whose screen row reaches the image height are dropped. A zero-size chunk
// ends the stream until a byte flagged new_transfer restarts the parser.
// Registers: x_origin at byte address 0, y_origin at byte address 4.
module chunked_image_stream_to_pixels #(
  parameter int COORD_BITS = cistp_pkg::COORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic [0:0]  s_tuser,   // [0] new_transfer
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [16:0] screen_x, [33:17] screen_y,
                                 // [49:34] pixel_color, [55:50] zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cistp_pkg::*;

  // config registers
  logic [15:0] x_origin;
  logic [15:0] y_origin;
  logic        cfg_write;

  // input handshake
  logic        accept;
  logic        new_transfer;
  logic [7:0]  stream_byte;

  data_evt_t   data_evt;
  geom_t       geom;

  // pixel pairing and walker
  logic                  toggle, toggle_next;
  logic [7:0]            held_high, held_high_next;
  logic [COORD_BITS-1:0] column, column_next;
  logic [COORD_BITS-1:0] row, row_next;
  logic                  tog_e;
  logic [COORD_BITS-1:0] col_e, row_e;
  logic [COORD_BITS:0]   col_inc;
  logic [16:0]           screen_x, screen_y;
  logic                  emit;

  // result register
  logic [16:0] out_x, out_y;
  logic [15:0] out_color;

  // ---- register port: pready tied high, write on access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= 16'd0;
      y_origin <= 16'd0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_X_ORIGIN: x_origin <= pwdata[15:0];
        REG_Y_ORIGIN: y_origin <= pwdata[15:0];
        default:      x_origin <= x_origin;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_X_ORIGIN: prdata = {16'd0, x_origin};
      REG_Y_ORIGIN: prdata = {16'd0, y_origin};
      default:      prdata = 32'd0;
    endcase
  end

  // ---- input side: take a byte whenever the result slot is free or draining
  assign s_tready     = !m_tvalid || m_tready;
  assign accept       = s_tvalid && s_tready;
  assign stream_byte  = s_tdata;
  assign new_transfer = s_tuser[0];

  cistp_chunk_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .stream_byte  (stream_byte),
    .new_transfer (new_transfer),
    .data_evt     (data_evt),
    .geom         (geom)
  );

  // ---- pixel pairing: first byte of a pair is held, second one emits unless clipped
  assign tog_e   = new_transfer ? 1'b0 : toggle;
  assign col_e   = new_transfer ? '0 : column;
  assign row_e   = new_transfer ? '0 : row;
  assign col_inc = {1'b0, col_e} + {{COORD_BITS{1'b0}}, 1'b1};

  // screen position: origin plus walker, one bit of growth
  assign screen_x = {1'b0, x_origin} + 17'(col_e);
  assign screen_y = {1'b0, y_origin} + 17'(row_e);

  always_comb begin
    toggle_next    = tog_e;
    held_high_next = held_high;
    column_next    = col_e;
    row_next       = row_e;
    emit           = 1'b0;
    if (data_evt.valid) begin
      if (!tog_e) begin
        held_high_next = data_evt.data;
        toggle_next    = 1'b1;
      end else begin
        toggle_next = 1'b0;
        // rows at or past the image height are clipped
        emit = screen_y < {1'b0, geom.height};
        // wrap the column when the next one reaches the width
        if (17'(col_inc) >= {1'b0, geom.width}) begin
          column_next = '0;
          row_next    = row_e + {{(COORD_BITS-1){1'b0}}, 1'b1};
        end else begin
          column_next = col_inc[COORD_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle <= 1'b0;
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      toggle <= toggle_next;
      column <= column_next;
      row    <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_high <= held_high_next;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_x     <= screen_x;
      out_y     <= screen_y;
      out_color <= {held_high, data_evt.data};
    end
  end

  assign m_tdata = {6'd0, out_color, out_y, out_x};

  // ---- checks
  // a restart byte can never finish a pixel
  a_restart_no_pixel: assert property (@(posedge clk) disable iff (rst)
    accept && new_transfer |=> !m_tvalid)
    else $error("pixel produced by a transfer restart byte");

  // the first byte of a pair only gets held
  a_first_byte_holds: assert property (@(posedge clk) disable iff (rst)
    accept && data_evt.valid && !tog_e |=> !m_tvalid)
    else $error("pixel produced by the first byte of a pair");

  // with the result slot empty the input is always open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result slot");

endmodule

FILE: test/chunked_image_stream_to_pixels_tb.sv
// ----------------------------------------------------------------------------
// chunked_image_stream_to_pixels_tb
// self-checking bench: feeds chunked image bodies byte by byte, decodes the
// same bytes in a behavioral pixel predictor and compares every placed pixel
// ----------------------------------------------------------------------------
module chunked_image_stream_to_pixels_tb;
  import cistp_pkg::*;

  // register byte addresses on the config port
  localparam logic [2:0] ADDR_X_ORIGIN = {REG_X_ORIGIN, 2'b00};
  localparam logic [2:0] ADDR_Y_ORIGIN = {REG_Y_ORIGIN, 2'b00};

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD     = 300;   // receiver back-pressure stretch
  localparam int NUM_SETTINGS  = 6;     // origin settings walked in the random part
  localparam int DIRECTED_ROWS = 25;

  // one placed pixel as it leaves on the master stream
  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [15:0] color;
  } pixel_t;

  // one row of the directed table; pinned rows carry a typed-in pixel
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       pinned;
    pixel_t     px;
  } stim_row_t;

  // directed rows, origin still at reset (0, 0)
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // overlong header: eleven bytes, letters of both cases, junk and slash,
    // closed on the 11th byte even though it is a proper LF -> chunk of 8192
    '{"F", 1'b1, 1'b0, '0},
    '{"f", 1'b0, 1'b0, '0},
    '{"/", 1'b0, 1'b0, '0},
    '{"z", 1'b0, 1'b0, '0},
    '{"a", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{"A", 1'b0, 1'b0, '0},
    '{" ", 1'b0, 1'b0, '0},
    '{"C", 1'b0, 1'b0, '0},
    '{ASCII_CR, 1'b0, 1'b0, '0},
    '{ASCII_LF, 1'b0, 1'b0, '0},
    // width 0, height 2: each pixel steps the row
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{17'd0, 17'd0, 16'hFFFF}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{17'd0, 17'd1, 16'h0000}},
    // third row is past the height and gets clipped
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    // restart, then a zero-size chunk ends the stream
    '{"0", 1'b1, 1'b0, '0},
    '{ASCII_CR, 1'b0, 1'b0, '0},
    '{ASCII_LF, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  always #2 clk = ~clk;

  chunked_image_stream_to_pixels dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // pixel predictor: its own copy of origins and parser state
  // --------------------------------------------------------------------------
  logic [15:0] x_org = 16'd0;
  logic [15:0] y_org = 16'd0;
  phase_t      dec_phase;
  logic [15:0] size_acc;
  logic [7:0]  last_byte, last_byte2;
  logic [3:0]  hdr_count;
  logic [15:0] chunk_len, chunk_count;
  logic        first_chunk;
  logic [15:0] img_w, img_h;
  logic [7:0]  high_byte;
  logic        odd_byte;
  logic [15:0] col, row;

  pixel_t pixels_due [$];   // pixels still to come out, oldest first

  int bytes_sent     = 0;
  int pixels_seen    = 0;
  int pixels_clipped = 0;
  int mismatches     = 0;
  int transfers_sent = 0;
  int noise_runs     = 0;
  int settings_used  = 0;

  bit     start_next = 1'b0;  // tuser for the next byte sent
  bit     pin_active = 1'b0;
  pixel_t pin_px     = '0;
  bit     calm       = 1'b0;  // no idling on either side
  bit     held_long  = 1'b0;

  function automatic void clear_parser();
    dec_phase   = PH_HEADER;
    size_acc    = 16'd0;
    last_byte   = 8'd0;
    last_byte2  = 8'd0;
    hdr_count   = 4'd0;
    chunk_len   = DEFAULT_CHUNK_LEN;
    chunk_count = 16'd0;
    first_chunk = 1'b1;
    img_w       = 16'd0;
    img_h       = 16'd0;
    high_byte   = 8'd0;
    odd_byte    = 1'b0;
    col         = 16'd0;
    row         = 16'd0;
  endfunction

  // advance the parser by one body byte; returns 1 when a pixel is placed
  function automatic bit decode_byte(input logic [7:0] b, input logic restart,
                                     output pixel_t px);
    logic        closes;
    logic [15:0] len;
    logic [3:0]  nib;
    logic [16:0] sy, nxt;
    decode_byte = 1'b0;
    px = '0;
    if (restart) clear_parser();
    // finished chunk: this byte opens the next header
    if (dec_phase == PH_DATA && chunk_count >= chunk_len) begin
      dec_phase = PH_HEADER;
      size_acc  = 16'd0;
      hdr_count = 4'd0;
    end
    case (dec_phase)
      PH_HEADER: begin
        closes = (b == ASCII_LF) && (last_byte == ASCII_CR) && (last_byte2 > ASCII_SLASH);
        hdr_count = hdr_count + 4'd1;
        if (b > ASCII_SLASH) begin
          nib = 4'd0;
          if (b >= ASCII_ZERO && b <= ASCII_NINE) nib = b[3:0];
          else if ((b >= ASCII_UPPER_A && b <= ASCII_UPPER_F) ||
                   (b >= ASCII_LOWER_A && b <= ASCII_LOWER_F)) nib = b[3:0] + 4'd9;
          size_acc = {size_acc[11:0], 4'd0} + {12'd0, nib};
        end
        last_byte2 = last_byte;
        last_byte  = b;
        len = size_acc;
        if (hdr_count > HDR_MAX_BYTES) begin
          closes = 1'b1;
          len    = DEFAULT_CHUNK_LEN;
        end
        if (closes && len == 16'd0) begin
          dec_phase = PH_DONE;
        end else if (closes) begin
          chunk_len   = len;
          chunk_count = 16'd0;
          dec_phase   = first_chunk ? PH_SIZE : PH_DATA;
          first_chunk = 1'b0;
        end
      end
      PH_SIZE: begin
        case (chunk_count[1:0])
          2'd0: img_w = {b, 8'd0};
          2'd1: img_w[7:0] = b;
          2'd2: img_h = {b, 8'd0};
          default: img_h[7:0] = b;
        endcase
        chunk_count = chunk_count + 16'd1;
        if (chunk_count >= 16'd4) dec_phase = PH_DATA;
      end
      PH_DATA: begin
        chunk_count = chunk_count + 16'd1;
        if (!odd_byte) begin
          high_byte = b;
          odd_byte  = 1'b1;
        end else begin
          odd_byte = 1'b0;
          sy = {1'b0, y_org} + {1'b0, row};
          if (sy < {1'b0, img_h}) begin
            px.x = {1'b0, x_org} + {1'b0, col};
            px.y = sy;
            px.color = {high_byte, b};
            decode_byte = 1'b1;
          end else begin
            pixels_clipped++;
          end
          // column walker, row steps when the column reaches the width
          nxt = {1'b0, col} + 17'd1;
          if (nxt >= {1'b0, img_w}) begin
            col = 16'd0;
            row = row + 16'd1;
          end else begin
            col = nxt[15:0];
          end
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers, all changes on the falling edge
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    pixel_t px;
    bit     made;
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start_next;
    do @(posedge clk); while (!s_tready);
    made = decode_byte(b, start_next, px);
    start_next = 1'b0;
    if (pin_active) pixels_due.push_back(pin_px);
    else if (made) pixels_due.push_back(px);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_X_ORIGIN: x_org = value;
      ADDR_Y_ORIGIN: y_org = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // hex size, CR LF; sometimes padded with zeros or with digits that the
  // 16-bit accumulator shifts out again
  task automatic send_header(input logic [15:0] len);
    logic [3:0]  nibs [$];
    logic [15:0] v;
    logic [7:0]  ch;
    int          style;
    style = $urandom_range(0, 9);
    v = len;
    if (style < 6) begin
      do begin
        nibs.push_front(v[3:0]);
        v = v >> 4;
      end while (v != 16'd0);
    end else begin
      repeat (4) begin
        nibs.push_front(v[3:0]);
        v = v >> 4;
      end
      if (style >= 8) repeat ($urandom_range(1, 3)) nibs.push_front(4'($urandom_range(0, 15)));
    end
    foreach (nibs[i]) begin
      if (nibs[i] < 4'd10) ch = ASCII_ZERO + nibs[i];
      else ch = ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + nibs[i] - 8'd10;
      send_byte(ch);
    end
    send_byte(ASCII_CR);
    send_byte(ASCII_LF);
  endtask

  // one image body split into random chunks, most of them ended by a zero-size chunk
  task automatic send_transfer();
    logic [7:0]  body [$];
    logic [15:0] w, h;
    int          pick, npx, len, take;
    pick = $urandom_range(0, 19);
    w = (pick < 2) ? 16'd0 : (pick == 2) ? 16'hFFFF :
        (pick == 3) ? 16'($urandom) : 16'($urandom_range(1, 6));
    pick = $urandom_range(0, 19);
    h = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
        (pick == 2) ? 16'($urandom) : 16'($urandom_range(1, 8));
    body.push_back(w[15:8]);
    body.push_back(w[7:0]);
    body.push_back(h[15:8]);
    body.push_back(h[7:0]);
    npx = $urandom_range(1, 20);
    repeat (2 * npx) body.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0) body.push_back(8'($urandom_range(0, 255)));
    start_next = 1'b1;
    // the four size bytes are always read, even from a shorter first chunk
    len = $urandom_range(1, 12);
    if (len > body.size()) len = body.size();
    send_header(16'(len));
    take = (len < 4) ? 4 : len;
    repeat (take) send_byte(body.pop_front());
    while (body.size() > 0) begin
      len = $urandom_range(1, 12);
      if (len > body.size()) len = body.size();
      send_header(16'(len));
      repeat (len) send_byte(body.pop_front());
    end
    // most bodies end properly, the rest are cut off by the next restart
    if ($urandom_range(0, 9) != 0) begin
      send_header(16'd0);
      send_byte(ASCII_CR);
      send_byte(ASCII_LF);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4))
        send_byte(8'($urandom_range(0, 255)));
    end
    transfers_sent++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 24)) begin
      start_next = ($urandom_range(0, 7) == 0);
      send_byte(8'($urandom_range(0, 255)));
    end
    noise_runs++;
  endtask

  // stop offering and let every predicted pixel come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // receiver: short random stalls, one long hold to back the block up
  // --------------------------------------------------------------------------
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held_long && !calm && pixels_seen >= 40) begin
        m_tready  <= 1'b0;
        held_long  = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // result checker: every accepted pixel against the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      pixels_seen++;
      if (pixels_due.size() == 0) begin
        $error("pixel with nothing predicted: x=%0d y=%0d color=%h",
               m_tdata[16:0], m_tdata[33:17], m_tdata[49:34]);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        if (m_tdata[16:0] !== want.x) begin
          $error("screen_x: expected %0d, got %0d", want.x, m_tdata[16:0]);
          mismatches++;
        end
        if (m_tdata[33:17] !== want.y) begin
          $error("screen_y: expected %0d, got %0d", want.y, m_tdata[33:17]);
          mismatches++;
        end
        if (m_tdata[49:34] !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, m_tdata[49:34]);
          mismatches++;
        end
        if (m_tdata[55:50] !== 6'd0) begin
          $error("tdata padding: expected 0, got %h", m_tdata[55:50]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d pixels outstanding",
               quiet_cycles, pixels_due.size());
      $display("chunked_image_stream_to_pixels regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int budget, phase_start;
    clear_parser();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      start_next = DIRECTED[i].start;
      pin_active = DIRECTED[i].pinned;
      pin_px     = DIRECTED[i].px;
      send_byte(DIRECTED[i].data);
    end
    pin_active = 1'b0;

    // random bodies under several origin settings; second setting clips all
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      write_register(ADDR_X_ORIGIN, (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0000 :
                                    16'($urandom));
      write_register(ADDR_Y_ORIGIN, (p == 1) ? 16'hFFFF : (p == 0) ? 16'h0000 :
                                    16'($urandom_range(0, 3)));
      settings_used++;
      calm = (p == NUM_SETTINGS - 1);
      budget = (p == 1) ? 120 : 250;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < budget) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_transfer();
      end
    end
    drain();

    $display("sent %0d bytes: %0d directed, %0d image bodies, %0d noise runs, %0d origins",
             bytes_sent, DIRECTED_ROWS, transfers_sent, noise_runs, settings_used + 1);
    $display("checked %0d pixels, %0d clipped by height, %0d mismatches",
             pixels_seen, pixels_clipped, mismatches);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("chunked_image_stream_to_pixels regression: pass");
    end else begin
      $display("chunked_image_stream_to_pixels regression: fail");
    end
    $finish;
  end

endmodule
